>>> src/salts_pkg.sv
// Shared types and constants of the set-associative LRU tag store.
// No dependencies; every other file of the block imports this package.
package salts_pkg;

	// Default geometry; the top level takes these as parameter defaults.
	localparam int SET_COUNT_DEF   = 64;
	localparam int WAYS_DEF        = 4;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam int ADDR_BITS_DEF   = 32;

	// LRU age counter of each line.
	localparam int          AGE_W   = 3;
	localparam logic [2:0]  AGE_MAX = 3'd7;

	// Fixed widths of the result fields.
	localparam int WAY_OUT_W  = 2;
	localparam int LINE_OUT_W = 8;

	typedef enum logic {
		KIND_LOOKUP = 1'b0,
		KIND_INSERT = 1'b1
	} salts_kind_t;

	// Status of one set update, from the set logic to the top level.
	typedef struct packed {
		logic found;
		logic filled_empty;
	} salts_res_t;

endpackage

>>> src/salts_if.sv
// Request and response channels of the LRU tag store (valid/ready handshake).
// Depends on salts_pkg for the result field widths.
interface salts_req_if #(
	parameter int ADDR_BITS = 32
) ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ADDR_BITS-1:0] address;

	modport source (output valid, output kind, output address, input ready);
	modport sink   (input valid, input kind, input address, output ready);
endinterface

interface salts_rsp_if import salts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [WAY_OUT_W-1:0]  way;
	logic [LINE_OUT_W-1:0] line_index;
	logic                  filled_empty;

	modport source (output valid, output found, output way, output line_index,
		output filled_empty, input ready);
	modport sink   (input valid, input found, input way, input line_index,
		input filled_empty, output ready);
endinterface

>>> src/salts_set_logic.sv
// Hit search, victim choice and LRU age update over the ways of one set.
// Purely combinational; depends on salts_pkg.
module salts_set_logic import salts_pkg::*; #(
	parameter int WAYS  = WAYS_DEF,
	parameter int TAG_W = 20,
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  salts_kind_t                  kind,
	input  logic [TAG_W-1:0]             tag,
	input  logic [WAYS-1:0]              vld,
	input  logic [WAYS-1:0][TAG_W-1:0]   tags,
	input  logic [WAYS-1:0][AGE_W-1:0]   ages,
	output logic [WAYS-1:0]              vld_nxt,
	output logic [WAYS-1:0][TAG_W-1:0]   tags_nxt,
	output logic [WAYS-1:0][AGE_W-1:0]   ages_nxt,
	output logic [WAY_W-1:0]             way,
	output salts_res_t                   res
);

	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             has_empty;
	logic [WAY_W-1:0] empty_way;
	logic [WAY_W-1:0] old_way;
	logic [WAYS-1:0]  is_oldest;
	logic [WAY_W-1:0] fill_way;
	logic [AGE_W-1:0] hit_age;

	// Lowest matching way and lowest invalid way: scan downward, last match wins.
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		has_empty = 1'b0;
		empty_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vld[w] && tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!vld[w]) begin
				has_empty = 1'b1;
				empty_way = WAY_W'(w);
			end
		end
	end

	// A way is oldest if no other way is older; take the highest such way.
	always_comb begin
		old_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			is_oldest[w] = 1'b1;
			for (int v = 0; v < WAYS; v++) begin
				if (ages[v] > ages[w]) begin
					is_oldest[w] = 1'b0;
				end
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (is_oldest[w]) begin
				old_way = WAY_W'(w);
			end
		end
	end

	assign fill_way = has_empty ? empty_way : old_way;
	assign hit_age  = ages[hit_way];

	always_comb begin
		vld_nxt  = vld;
		tags_nxt = tags;
		ages_nxt = ages;
		way      = '0;
		res      = '0;
		case (kind)
			KIND_LOOKUP: begin
				if (hit) begin
					for (int w = 0; w < WAYS; w++) begin
						if (ages[w] < hit_age) begin
							ages_nxt[w] = ages[w] + AGE_W'(1);
						end
					end
					ages_nxt[hit_way] = '0;
					way               = hit_way;
					res.found         = 1'b1;
				end
			end
			KIND_INSERT: begin
				for (int w = 0; w < WAYS; w++) begin
					if (ages[w] < AGE_MAX) begin
						ages_nxt[w] = ages[w] + AGE_W'(1);
					end
				end
				ages_nxt[fill_way] = '0;
				vld_nxt[fill_way]  = 1'b1;
				tags_nxt[fill_way] = tag;
				way                = fill_way;
				res.found          = 1'b1;
				res.filled_empty   = has_empty;
			end
			default: begin
				way = '0;
			end
		endcase
	end

endmodule

>>> src/set_assoc_lru_tag_store.sv
// Set-associative cache tag and LRU store: one set row read, updated, written per transaction.
// Accept loads stage 1 with a registered row read; advance loads the response register.
// Throughput one transaction per cycle while rsp.ready does not stall, set by the single read
// and single write port of the set-row memory. Reset: a clearing pass writes every set row to
// zero, one row a cycle, with req.ready low; the first request is accepted after it completes.
// Depends on salts_pkg, salts_if.sv and salts_set_logic.
module set_assoc_lru_tag_store import salts_pkg::*; #(
	parameter int SET_COUNT   = SET_COUNT_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	salts_req_if.sink    req,
	salts_rsp_if.source  rsp
);

	// Address split; SET_COUNT and BLOCK_BYTES are powers of two, so fields are bit slices.
	localparam int OFF_BITS = $clog2(BLOCK_BYTES);
	localparam int SET_BITS = $clog2(SET_COUNT);
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_BITS - OFF_BITS - SET_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int IDX_W    = $clog2(SET_COUNT * WAYS + 1);
	localparam int ROW_W    = WAYS * (1 + TAG_W + AGE_W);
	localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(SET_COUNT - 1);

	// Request decode.
	logic [ADDR_BITS-1:0] blk;
	logic [SET_W-1:0]     req_set;
	logic [TAG_W-1:0]     req_tag;
	logic                 acc;

	// Stage 1: accepted request and registered memory row.
	logic                 vld_s1;
	salts_kind_t          kind_s1;
	logic [SET_W-1:0]     set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [ROW_W-1:0]     rd_s1;
	logic                 fwd_s1;
	logic [ROW_W-1:0]     byp_q;
	logic                 adv;

	// Current and next set row, split per way.
	logic [ROW_W-1:0]                row_cur;
	logic [ROW_W-1:0]                row_nxt;
	logic [WAYS-1:0]                 row_vld;
	logic [WAYS-1:0][TAG_W-1:0]      row_tags;
	logic [WAYS-1:0][AGE_W-1:0]      row_ages;
	logic [WAYS-1:0]                 nxt_vld;
	logic [WAYS-1:0][TAG_W-1:0]      nxt_tags;
	logic [WAYS-1:0][AGE_W-1:0]      nxt_ages;
	logic [WAY_W-1:0]                upd_way;
	salts_res_t                      upd_res;
	logic [IDX_W-1:0]                upd_idx;

	// Set-row memory and its write port.
	logic [ROW_W-1:0] mem [SET_COUNT];
	logic             mem_we;
	logic [SET_W-1:0] mem_wa;
	logic [ROW_W-1:0] mem_wd;

	// Reset clearing pass.
	logic             clr_q;
	logic [SET_W-1:0] clr_cnt_q;

	// Response register.
	logic                  out_vld_q;
	logic                  found_q;
	logic [WAY_OUT_W-1:0]  way_q;
	logic [LINE_OUT_W-1:0] line_q;
	logic                  empty_q;

	assign blk     = req.address >> OFF_BITS;
	assign req_set = SET_W'(blk & SET_MASK);
	assign req_tag = TAG_W'(blk >> SET_BITS);

	// Advance stage 1 when the response slot is free or drains this cycle.
	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !clr_q && (!vld_s1 || adv);
	assign acc       = req.valid && req.ready;

	// Clearing pass: one zero row per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == SET_W'(SET_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	// Memory write: clearing pass, else write back the updated row on advance.
	// A lookup miss writes the unchanged row, which keeps the forwarding simple.
	assign mem_we = clr_q || adv;
	assign mem_wa = clr_q ? clr_cnt_q : set_s1;
	assign mem_wd = clr_q ? '0 : row_nxt;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Registered read of the requested set row on accept.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[req_set];
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
			// The read above misses the write-back of the row leaving stage 1 now.
			fwd_s1 <= adv && (set_s1 == req_set);
		end else if (adv) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	// Stage 1 payload; the bypass row holds the last written-back row.
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= salts_kind_t'(req.kind);
			set_s1  <= req_set;
			tag_s1  <= req_tag;
		end
		if (adv) begin
			byp_q <= row_nxt;
		end
	end

	assign row_cur                      = fwd_s1 ? byp_q : rd_s1;
	assign {row_vld, row_tags, row_ages} = row_cur;
	assign row_nxt                      = {nxt_vld, nxt_tags, nxt_ages};

	salts_set_logic #(
		.WAYS  (WAYS),
		.TAG_W (TAG_W)
	) u_set_logic (
		.kind     (kind_s1),
		.tag      (tag_s1),
		.vld      (row_vld),
		.tags     (row_tags),
		.ages     (row_ages),
		.vld_nxt  (nxt_vld),
		.tags_nxt (nxt_tags),
		.ages_nxt (nxt_ages),
		.way      (upd_way),
		.res      (upd_res)
	);

	// Line index in the external data memory: set * WAYS + way, zero on a miss.
	assign upd_idx = upd_res.found
		? IDX_W'(set_s1) * IDX_W'(WAYS) + IDX_W'(upd_way)
		: '0;

	// Response register: hold while stalled, load on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q <= upd_res.found;
			way_q   <= WAY_OUT_W'(upd_way);
			line_q  <= LINE_OUT_W'(upd_idx);
			empty_q <= upd_res.filled_empty;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.found        = found_q;
	assign rsp.way          = way_q;
	assign rsp.line_index   = line_q;
	assign rsp.filled_empty = empty_q;

	// No request is taken during the clearing pass.
	a_no_acc_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !req.ready)
		else $error("request accepted during clearing pass");

	// The clearing pass ends only after the last set row.
	a_clr_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_cnt_q) == SET_W'(SET_COUNT - 1))
		else $error("clearing pass ended early");

	// Forwarding only applies to an occupied stage.
	a_fwd_vld: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> vld_s1)
		else $error("row bypass selected with empty stage");

	// An insert always reports a filled line.
	a_ins_found: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_INSERT) |=> (rsp.valid && rsp.found))
		else $error("insert response without found");

	// A lookup never reports an empty fill.
	a_lkp_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == KIND_LOOKUP) |=> !rsp.filled_empty)
		else $error("lookup response flags filled_empty");

endmodule

>>> test/tb.sv
// Self-checking testbench of set_assoc_lru_tag_store: random and directed cache accesses,
// each response checked against a cycle-free tag and LRU-age model kept here.
// Depends on salts_pkg, salts_if.sv and the block's RTL.
`timescale 1ns / 100ps

module tb;
	import salts_pkg::*;

	// Geometry of the instance under test; all defaults from the package.
	localparam int SET_COUNT = SET_COUNT_DEF;
	localparam int WAYS      = WAYS_DEF;
	localparam int ADDR_BITS = ADDR_BITS_DEF;
	localparam int OFFSET_W  = $clog2(BLOCK_BYTES_DEF);
	localparam int SET_W     = $clog2(SET_COUNT);
	localparam int TAG_W     = ADDR_BITS - OFFSET_W - SET_W;
	localparam int LINES     = SET_COUNT * WAYS;

	typedef struct packed {
		salts_kind_t          kind;
		logic [ADDR_BITS-1:0] address;
	} access_t;

	typedef struct packed {
		logic                  found;
		logic [WAY_OUT_W-1:0]  way;
		logic [LINE_OUT_W-1:0] line_index;
		logic                  filled_empty;
	} tag_outcome_t;

	logic clk;
	logic arst_n;

	salts_req_if #(.ADDR_BITS(ADDR_BITS)) req_ch ();
	salts_rsp_if                          rsp_ch ();

	set_assoc_lru_tag_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model copy of the tag store: one entry per line, indexed set * WAYS + way.
	logic             line_valid [LINES];
	logic [TAG_W-1:0] line_tag   [LINES];
	logic [AGE_W-1:0] line_age   [LINES];

	access_t      access_q[$];       // accesses waiting to be driven
	tag_outcome_t tag_outcomes_q[$]; // predicted responses, oldest first
	tag_outcome_t seen_outcome;

	int mismatch_count = 0;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	bit hold_requests  = 1'b0;
	bit req_taken      = 1'b0;

	// Working set of the random part: few sets, a few more tags than ways,
	// so that hits, misses and evictions all come often.
	logic [SET_W-1:0] hot_sets [3];
	logic [TAG_W-1:0] hot_tags [6];

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Compute the response of one access and apply its effect on tags and ages.
	function automatic tag_outcome_t tag_store_access(access_t acc);
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		int               base;
		int               hit_way;
		int               victim;
		bit               got_empty;
		logic [AGE_W-1:0] ref_age;
		tag_outcome_t     res;

		set_idx   = acc.address[OFFSET_W +: SET_W];
		tag       = acc.address[ADDR_BITS-1 -: TAG_W];
		base      = int'(set_idx) * WAYS;
		res       = '0;
		hit_way   = -1;
		victim    = 0;
		got_empty = 1'b0;
		ref_age   = '0;

		if (acc.kind == KIND_LOOKUP) begin
			// First valid way with a matching tag wins, even if a duplicate sits higher.
			for (int w = 0; w < WAYS; w++) begin
				if (hit_way < 0 && line_valid[base + w] && line_tag[base + w] == tag)
					hit_way = w;
			end
			// On a miss leave the set alone; the response stays all zero.
			if (hit_way >= 0) begin
				ref_age = line_age[base + hit_way];
				for (int w = 0; w < WAYS; w++) begin
					if (line_age[base + w] < ref_age)
						line_age[base + w] = line_age[base + w] + AGE_W'(1);
				end
				line_age[base + hit_way] = '0;
				res.found      = 1'b1;
				res.way        = WAY_OUT_W'(hit_way);
				res.line_index = LINE_OUT_W'(base + hit_way);
			end
		end else begin
			// Take the first invalid way; else the last way holding the greatest age.
			for (int w = 0; w < WAYS; w++) begin
				if (!got_empty) begin
					if (!line_valid[base + w]) begin
						victim    = w;
						got_empty = 1'b1;
					end else if (line_age[base + w] >= ref_age) begin
						ref_age = line_age[base + w];
						victim  = w;
					end
				end
			end
			// Age every way, saturating, then install the new line as youngest.
			for (int w = 0; w < WAYS; w++) begin
				if (line_age[base + w] < AGE_MAX)
					line_age[base + w] = line_age[base + w] + AGE_W'(1);
			end
			line_age[base + victim]   = '0;
			line_valid[base + victim] = 1'b1;
			line_tag[base + victim]   = tag;
			res.found        = 1'b1;
			res.way          = WAY_OUT_W'(victim);
			res.line_index   = LINE_OUT_W'(base + victim);
			res.filled_empty = got_empty;
		end
		return res;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Driver: change inputs on the falling edge only. Hold a pending transaction
	// until it is taken; advance to the next queued access or idle otherwise.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (hold_requests || access_q.size() == 0 ||
			    $urandom_range(99) < send_gap_pct) begin
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid   <= 1'b1;
				req_ch.kind    <= access_q[0].kind;
				req_ch.address <= access_q[0].address;
				void'(access_q.pop_front());
			end
		end
		// Stall the response side at random.
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: sample both channels on the rising edge. Check the response first,
	// so that a transaction accepted at the same edge never matches itself.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (tag_outcomes_q.size() == 0) begin
					report_mismatch("response with nothing outstanding", 32'd0, 32'd1);
				end else begin
					seen_outcome = tag_outcomes_q.pop_front();
					if (rsp_ch.found !== seen_outcome.found)
						report_mismatch("found", 32'(seen_outcome.found),
							32'(rsp_ch.found));
					if (rsp_ch.way !== seen_outcome.way)
						report_mismatch("way", 32'(seen_outcome.way), 32'(rsp_ch.way));
					if (rsp_ch.line_index !== seen_outcome.line_index)
						report_mismatch("line_index", 32'(seen_outcome.line_index),
							32'(rsp_ch.line_index));
					if (rsp_ch.filled_empty !== seen_outcome.filled_empty)
						report_mismatch("filled_empty", 32'(seen_outcome.filled_empty),
							32'(rsp_ch.filled_empty));
				end
			end
			if (req_ch.valid && req_ch.ready)
				tag_outcomes_q.push_back(tag_store_access({salts_kind_t'(req_ch.kind),
					req_ch.address}));
		end
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
	end

	function automatic logic [ADDR_BITS-1:0] line_address(logic [TAG_W-1:0] tag,
			logic [SET_W-1:0] set_idx, logic [OFFSET_W-1:0] offset);
		return {tag, set_idx, offset};
	endfunction

	task automatic push_access(salts_kind_t kind, logic [ADDR_BITS-1:0] address);
		access_q.push_back({kind, address});
	endtask

	// Mostly accesses into the working set; the rest spread over the whole address space.
	task automatic push_random_access();
		salts_kind_t kind;
		if ($urandom_range(99) < 75) begin
			kind = ($urandom_range(99) < 60) ? KIND_LOOKUP : KIND_INSERT;
			push_access(kind, line_address(hot_tags[$urandom_range(5)],
				hot_sets[$urandom_range(2)], OFFSET_W'($urandom)));
		end else begin
			kind = salts_kind_t'($urandom_range(1));
			push_access(kind, ADDR_BITS'($urandom));
		end
	endtask

	task automatic pick_working_set();
		foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom);
		foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom);
	endtask

	// One idling profile: queue the accesses, pause the sender halfway until every
	// response is back, then drain everything.
	task automatic run_phase(int gap_pct, int stall_pct, int count);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		pick_working_set();
		repeat (count) push_random_access();
		while (access_q.size() > count / 2) @(posedge clk);
		hold_requests = 1'b1;
		while (req_ch.valid || tag_outcomes_q.size() != 0) @(posedge clk);
		hold_requests = 1'b0;
		while (access_q.size() != 0 || req_ch.valid || tag_outcomes_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.kind     = 1'b0;
		req_ch.address  = '0;
		rsp_ch.ready    = 1'b0;
		foreach (line_valid[i]) begin
			line_valid[i] = 1'b0;
			line_tag[i]   = '0;
			line_age[i]   = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes of the address, miss on an empty store, hits,
		// a full set with LRU replacement, and a duplicate tag.
		push_access(KIND_LOOKUP, '0);
		push_access(KIND_INSERT, '0);
		push_access(KIND_LOOKUP, 32'h0000_003F);
		push_access(KIND_LOOKUP, '1);
		push_access(KIND_INSERT, '1);
		push_access(KIND_LOOKUP, 32'hFFFF_FFC0);
		for (int t = 1; t <= 4; t++)
			push_access(KIND_INSERT, line_address(TAG_W'(t), SET_W'(5), '0));
		push_access(KIND_LOOKUP, line_address(TAG_W'(2), SET_W'(5), '1));
		// Set is full: evict the oldest line, then refresh one way and evict again.
		push_access(KIND_INSERT, line_address(TAG_W'(5), SET_W'(5), '0));
		push_access(KIND_LOOKUP, line_address(TAG_W'(1), SET_W'(5), '0));
		push_access(KIND_LOOKUP, line_address(TAG_W'(3), SET_W'(5), '0));
		push_access(KIND_INSERT, line_address(TAG_W'(6), SET_W'(5), '0));
		// Second copy of a tag that is present; the lookup must take the lower way.
		push_access(KIND_INSERT, line_address(TAG_W'(3), SET_W'(5), '0));
		push_access(KIND_LOOKUP, line_address(TAG_W'(3), SET_W'(5), '0));
		push_access(KIND_LOOKUP, line_address(TAG_W'(7), SET_W'(5), '0));
		// Partly filled set: ages of invalid ways move too.
		push_access(KIND_INSERT, line_address('1, SET_W'(9), '0));
		push_access(KIND_INSERT, line_address(TAG_W'(1), SET_W'(9), '0));
		push_access(KIND_LOOKUP, line_address('1, SET_W'(9), '1));
		push_access(KIND_INSERT, line_address(TAG_W'(2), SET_W'(9), '0));

		run_phase(9, 77, 600);
		run_phase(77, 9, 620);
		run_phase(0, 0, 610);

		// Give a stray late response time to show up.
		repeat (20) @(posedge clk);
		if (tag_outcomes_q.size() != 0)
			report_mismatch("responses never delivered", 32'd0, 32'(tag_outcomes_q.size()));

		if (mismatch_count == 0)
			$display("** set_assoc_lru_tag_store: PASSED **");
		else
			$display("** set_assoc_lru_tag_store: FAILED **");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("** set_assoc_lru_tag_store: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
src/salts_pkg.sv
src/salts_if.sv
src/salts_set_logic.sv
src/set_assoc_lru_tag_store.sv
test/tb.sv
